// ----- src/dclru_pkg.sv -----
package dclru_pkg;

  // Cache geometry
  localparam int SETS    = 256;
  localparam int WAYS    = 8;
  localparam int SET_W   = $clog2(SETS);
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W   = WAY_W;
  localparam int SET_LSB = 5;

  // Field widths
  localparam int ADDR_W    = 32;
  localparam int WORD_W    = 32;
  localparam int TAG_LSB   = 2;
  localparam int TAG_W     = ADDR_W - TAG_LSB;
  localparam int WAY_OUT_W = 3;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Access kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef logic [SET_W-1:0]  set_idx_t;
  typedef logic [WAY_W-1:0]  way_idx_t;
  typedef logic [AGE_W-1:0]  age_t;
  typedef logic [TAG_W-1:0]  tag_t;
  typedef logic [WORD_W-1:0] word_t;

  // Classified request handed from the front to the back
  typedef struct packed {
    logic     kind;
    set_idx_t set_idx;
    tag_t     tag;
    word_t    fill_word;
  } req_t;

  // One way of a set row
  typedef struct packed {
    logic  valid;
    age_t  age;
    tag_t  tag;
    word_t word;
  } way_entry_t;

  typedef way_entry_t [WAYS-1:0] row_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } back_state_t;

endpackage

// ----- src/dclru_if.sv -----
interface dclru_in_if import dclru_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              kind;
  logic [ADDR_W-1:0] word_address;
  logic [WORD_W-1:0] write_word;
  logic [WORD_W-1:0] memory_word;

  modport source (output valid, kind, word_address, write_word, memory_word, input ready);
  modport sink   (input valid, kind, word_address, write_word, memory_word, output ready);
endinterface

interface dclru_out_if import dclru_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 hit;
  logic [WAY_OUT_W-1:0] way_used;
  logic [WORD_W-1:0]    read_word;

  modport source (output valid, hit, way_used, read_word, input ready);
  modport sink   (input valid, hit, way_used, read_word, output ready);
endinterface

// ----- src/data_cache_lru_write_through.sv -----
// Each access passes through the front stage, the queue, the row read, then
//   lookup and write-back.
// The back end takes one access at a time, reading then writing back the set
//   row; the front keeps accepting into the queue while it has room.
// Reset: synchronous active-low rst_n empties front, queue and output and marks
//   every set untouched at once, so no clearing pass follows reset.
module data_cache_lru_write_through_core import dclru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dclru_in_if.sink    in_ch,
  dclru_out_if.source out_ch
);

  logic push_valid, push_ready;
  req_t push_req;
  logic q_valid, q_ready;
  req_t q_req;
  logic q_pop;

  dclru_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req)
  );

  dclru_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_req   (push_req),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_req   (q_req)
  );

  dclru_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (q_valid),
    .req_ready (q_ready),
    .req_in    (q_req),
    .out_ch    (out_ch)
  );

  assign q_pop = q_valid && q_ready;

  // The back end takes one access at a time
  a_single_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> !q_pop)
    else $error("back end took two accesses in a row");

  // A fresh result follows an earlier queue transfer
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(q_pop, 2))
    else $error("result appeared without a matching queue transfer");

endmodule

// ----- src/dclru_front.sv -----
module dclru_front import dclru_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dclru_in_if.sink    in_ch,
  output logic        push_valid,
  input  logic        push_ready,
  output req_t        push_req
);

  logic valid_r, valid_nxt;
  req_t req_r, req_nxt;
  logic take;

  assign in_ch.ready = !valid_r || push_ready;
  assign take        = in_ch.valid && in_ch.ready;

  // Classify: split address into set and tag, pick the word to store
  always_comb begin
    req_nxt           = req_r;
    req_nxt.kind      = in_ch.kind;
    req_nxt.set_idx   = in_ch.word_address[SET_LSB +: SET_W];
    req_nxt.tag       = in_ch.word_address[ADDR_W-1:TAG_LSB];
    req_nxt.fill_word = (in_ch.kind == KIND_WRITE) ? in_ch.write_word : in_ch.memory_word;
  end

  // Hold the stage until the queue takes it
  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r <= req_nxt;
    end
  end

  assign push_valid = valid_r;
  assign push_req   = req_r;

endmodule

// ----- src/dclru_queue.sv -----
module dclru_queue import dclru_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  req_t wr_req,
  output logic rd_valid,
  input  logic rd_ready,
  output req_t rd_req
);

  req_t              slot_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;

  assign wr_ready = (count_r != QCNT_W'(QDEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_req   = slot_r[rd_ptr_r];

  // Advance pointers with wrap at the queue depth
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_req;
    end
  end

endmodule

// ----- src/dclru_back.sv -----
module dclru_back import dclru_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         req_valid,
  output logic         req_ready,
  input  req_t         req_in,
  dclru_out_if.source  out_ch
);

  // Set rows: all ways of one set side by side
  row_t            row_mem [SETS];
  logic [SETS-1:0] touched_r;

  back_state_t state_r, state_nxt;
  req_t        req_r;
  row_t        rd_row_r;
  logic        rd_init_r;

  logic        out_valid_r, out_valid_nxt;
  logic        out_hit_r;
  way_idx_t    out_way_r;
  word_t       out_word_r;

  logic        pop, exec_go;
  row_t        cur_row, new_row;
  logic [WAYS-1:0] hit_vec;
  logic        hit;
  way_idx_t    hit_way, victim_way, chosen;
  age_t        pivot;
  logic        fill;
  word_t       result_word;

  assign req_ready = (state_r == ST_IDLE);
  assign pop       = req_valid && req_ready;
  assign exec_go   = (state_r == ST_EXEC) && (!out_valid_r || out_ch.ready);

  // Untouched sets read as invalid with age equal to way number
  always_comb begin
    cur_row = rd_row_r;
    for (int w = 0; w < WAYS; w++) begin
      if (!rd_init_r) begin
        cur_row[w].valid = 1'b0;
        cur_row[w].age   = AGE_W'(w);
      end
    end
  end

  // Compare all ways, find the hit way and the oldest way
  always_comb begin
    hit_way    = '0;
    victim_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = cur_row[w].valid && (cur_row[w].tag == req_r.tag);
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit_way = WAY_W'(w);
      end
      if (cur_row[w].age == AGE_W'(WAYS - 1)) begin
        victim_way = WAY_W'(w);
      end
    end
    hit    = |hit_vec;
    chosen = hit ? hit_way : victim_way;
    pivot  = cur_row[chosen].age;
    fill   = (req_r.kind == KIND_WRITE) || !hit;
  end

  // Age younger ways, reset the chosen way, store on fill
  always_comb begin
    new_row = cur_row;
    for (int w = 0; w < WAYS; w++) begin
      if (cur_row[w].age < pivot) begin
        new_row[w].age = cur_row[w].age + 1'b1;
      end
    end
    new_row[chosen].age = '0;
    if (fill) begin
      new_row[chosen].valid = 1'b1;
      new_row[chosen].tag   = req_r.tag;
      new_row[chosen].word  = req_r.fill_word;
    end
    result_word = fill ? req_r.fill_word : cur_row[chosen].word;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (pop) state_nxt = ST_EXEC;
      ST_EXEC: if (exec_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (exec_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      touched_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec_go) begin
        touched_r[req_r.set_idx] <= 1'b1;
      end
    end
  end

  // Row memory: read on pop, write back on execute
  always_ff @(posedge clk) begin
    if (exec_go) begin
      row_mem[req_r.set_idx] <= new_row;
    end
    if (pop) begin
      rd_row_r <= row_mem[req_in.set_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      req_r     <= req_in;
      rd_init_r <= touched_r[req_in.set_idx];
    end
    if (exec_go) begin
      out_hit_r  <= hit;
      out_way_r  <= chosen;
      out_word_r <= result_word;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.hit       = out_hit_r;
  assign out_ch.way_used  = WAY_OUT_W'(out_way_r);
  assign out_ch.read_word = out_word_r;

endmodule

// ----- bench/tb_data_cache_lru_write_through_core.sv -----
`timescale 1ns / 1ps

module tb_data_cache_lru_write_through_core;
  import dclru_pkg::*;

  localparam int ITEMS_PER_PHASE = 470;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 20;
  localparam int LIMIT_CYCLES    = 400000;
  localparam int POOL_SIZE       = 12;
  localparam int HOT_SETS        = 4;
  localparam int MAX_REPORTS     = 10;

  typedef struct packed {
    logic                 hit;
    logic [WAY_OUT_W-1:0] way_used;
    word_t                read_word;
  } cache_response_t;

  // Shadow copy of the cache plus the queue of responses it predicts
  class cache_mirror;
    bit              line_valid [SETS][WAYS];
    int unsigned     line_age   [SETS][WAYS];
    word_t           line_tag   [SETS][WAYS];
    word_t           line_data  [SETS][WAYS];
    cache_response_t expected_responses[$];
    int              errors;

    function new();
      for (int s = 0; s < SETS; s++) begin
        for (int w = 0; w < WAYS; w++) begin
          line_valid[s][w] = 1'b0;
          line_age[s][w]   = w;
          line_tag[s][w]   = '0;
          line_data[s][w]  = '0;
        end
      end
      errors = 0;
    endfunction

    // Look up, pick the way, age the set and queue the response
    function void note_access(logic kind, logic [ADDR_W-1:0] addr_raw,
                              word_t wdata, word_t mdata);
      logic [ADDR_W-1:0] addr;
      int                set_no;
      int                way;
      bit                found;
      int unsigned       pivot;
      cache_response_t   resp;
      addr   = {addr_raw[ADDR_W-1:TAG_LSB], {TAG_LSB{1'b0}}};
      set_no = int'((addr >> SET_LSB) % SETS);
      found  = 1'b0;
      way    = 0;
      for (int w = 0; w < WAYS; w++) begin
        if (!found && line_valid[set_no][w] && line_tag[set_no][w] == addr) begin
          found = 1'b1;
          way   = w;
        end
      end
      // Replace the oldest way, lowest number first on a tie
      if (!found) begin
        for (int w = 1; w < WAYS; w++) begin
          if (line_age[set_no][w] > line_age[set_no][way]) way = w;
        end
      end
      pivot = line_age[set_no][way];
      for (int w = 0; w < WAYS; w++) begin
        if (line_age[set_no][w] < pivot) line_age[set_no][w]++;
      end
      line_age[set_no][way] = 0;
      if (kind == KIND_WRITE) begin
        line_tag[set_no][way]   = addr;
        line_data[set_no][way]  = wdata;
        line_valid[set_no][way] = 1'b1;
      end else if (!found) begin
        line_tag[set_no][way]   = addr;
        line_data[set_no][way]  = mdata;
        line_valid[set_no][way] = 1'b1;
      end
      resp.hit       = found;
      resp.way_used  = WAY_OUT_W'(way);
      resp.read_word = line_data[set_no][way];
      expected_responses.push_back(resp);
    endfunction

    function void flag(string field, logic [WORD_W-1:0] exp_val,
                       logic [WORD_W-1:0] act_val);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("[%0t] mismatch on %s: expected %h, got %h", $realtime, field,
                 exp_val, act_val);
    endfunction

    // Compare one response against the oldest prediction
    function void check_response(cache_response_t got);
      cache_response_t exp_resp;
      if (expected_responses.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] response with nothing pending: hit %b way %0d word %h",
                   $realtime, got.hit, got.way_used, got.read_word);
        return;
      end
      exp_resp = expected_responses.pop_front();
      if (got.hit !== exp_resp.hit)
        flag("hit", WORD_W'(exp_resp.hit), WORD_W'(got.hit));
      if (got.way_used !== exp_resp.way_used)
        flag("way_used", WORD_W'(exp_resp.way_used), WORD_W'(got.way_used));
      if (got.read_word !== exp_resp.read_word)
        flag("read_word", exp_resp.read_word, got.read_word);
    endfunction

    function int pending();
      return expected_responses.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 1'b0;
  int          cycle_count = 0;
  cache_mirror mirror;
  logic [ADDR_W-1:0] addr_pool [POOL_SIZE];
  set_idx_t          hot_set   [HOT_SETS];

  dclru_in_if  in_ch ();
  dclru_out_if out_ch ();

  data_cache_lru_write_through_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Watch both channels and feed every transfer to the mirror
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        mirror.note_access(in_ch.kind, in_ch.word_address, in_ch.write_word,
                           in_ch.memory_word);
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
        mirror.check_response('{out_ch.hit, out_ch.way_used, out_ch.read_word});
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b1;
    forever begin
      @(posedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Abort a hung run
  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one access and hold it until the transfer
  task automatic send_access(input logic kind, input logic [ADDR_W-1:0] addr,
                             input word_t wdata, input word_t mdata);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.kind         <= kind;
    in_ch.word_address <= addr;
    in_ch.write_word   <= wdata;
    in_ch.memory_word  <= mdata;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
  endtask

  // Mostly addresses that compete for a few sets, some anywhere
  task automatic send_random();
    logic [ADDR_W-1:0] addr;
    int unsigned       r;
    logic              kind;
    r = $urandom_range(99);
    if (r < 5) begin
      addr = $urandom;
    end else begin
      addr = addr_pool[$urandom_range(POOL_SIZE - 1)];
      if (r < 85) addr[SET_LSB +: SET_W] = hot_set[$urandom_range(HOT_SETS - 1)];
      else addr[SET_LSB +: SET_W] = set_idx_t'($urandom_range(SETS - 1));
      addr[TAG_LSB-1:0] = ($urandom_range(9) == 0) ? TAG_LSB'($urandom) : '0;
    end
    kind = ($urandom_range(99) < 35) ? KIND_WRITE : KIND_READ;
    send_access(kind, addr, $urandom, $urandom);
  endtask

  initial begin
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] first_addr;
    int                idle_plan  [4];
    int                stall_plan [4];

    idle_plan  = '{0, 51, 0, 25};
    stall_plan = '{0, 0, 51, 25};
    mirror = new();
    for (int i = 0; i < POOL_SIZE; i++) addr_pool[i] = $urandom;
    for (int i = 0; i < HOT_SETS; i++) hot_set[i] = set_idx_t'($urandom_range(SETS - 1));

    in_ch.valid        <= 1'b0;
    in_ch.kind         <= KIND_READ;
    in_ch.word_address <= '0;
    in_ch.write_word   <= '0;
    in_ch.memory_word  <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme addresses and words, ignored low bits
    send_access(KIND_READ,  32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_access(KIND_READ,  32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(KIND_WRITE, 32'hFFFF_FFFC, 32'hFFFF_FFFF, 32'h0000_0000);
    send_access(KIND_READ,  32'hFFFF_FFFF, 32'h0000_0000, 32'h1234_5678);
    send_access(KIND_WRITE, 32'h0000_0003, 32'h0000_0000, 32'hFFFF_FFFF);
    send_access(KIND_READ,  32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    // Directed: overfill one set so the oldest way gets replaced
    first_addr = '0;
    for (int i = 0; i <= WAYS; i++) begin
      addr = '0;
      addr[SET_LSB +: SET_W]  = set_idx_t'(1);
      addr[ADDR_W-1 -: 8]     = 8'(i + 1);
      addr[TAG_LSB +: 3]      = 3'(i);
      if (i == 0) first_addr = addr;
      send_access((i % 2 == 0) ? KIND_WRITE : KIND_READ, addr, $urandom, $urandom);
    end
    send_access(KIND_READ,  first_addr, 32'h0000_0000, 32'h0000_0000);
    send_access(KIND_WRITE, first_addr, 32'hA5A5_5A5A, 32'hFFFF_FFFF);
    send_access(KIND_READ,  first_addr | 32'h2, 32'h0000_0000, 32'h0000_0000);
    send_access(KIND_READ,  addr, 32'h0000_0000, 32'h0000_0000);

    // Random traffic under each idling mix; the first phase also backs up the block
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = idle_plan[p];
      recv_stall_pct = stall_plan[p];
      if (p == 0) hold_req = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random();
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    // Drain outstanding responses, then let the pipeline settle
    while (mirror.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mirror.errors == 0 && mirror.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/dclru_pkg.sv
src/dclru_if.sv
src/dclru_front.sv
src/dclru_queue.sv
src/dclru_back.sv
src/data_cache_lru_write_through.sv
bench/tb_data_cache_lru_write_through_core.sv
